### rtl/assert_macros.svh
// Assertion helpers: clocked on the block clock, disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication property at each rising clock edge outside reset.
`define ASSERT_CLKD(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition holds at each rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

`endif

### rtl/mm3_pkg.sv
`default_nettype none

package mm3_pkg;

    localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2  = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] MIX_M5  = 32'd5;
    localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;

    function automatic logic [31:0] rotl15(input logic [31:0] v);
        return {v[16:0], v[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] v);
        return {v[18:0], v[31:19]};
    endfunction

endpackage

`default_nettype wire

### rtl/murmur3_x86_32_hash_stream.sv
// MurmurHash3 x86_32 over a byte stream, seeded by a configuration register.
// Input channel s_*: one request per message byte. s_tdata carries the byte,
// s_tuser says whether the byte belongs to the message (0 marks an empty
// request), s_tlast closes the message. Output channel m_*: one 32-bit hash
// per message, sent after the request marked last.
// cfg_*: writes the seed; it is sampled when the next message starts.
// Sequencing: all multiplies run through a single 32x32 multiplier under a
// small sequencer. A byte that does not complete a 4-byte block is absorbed
// in the idle state; a byte that completes a block passes KMUL1, KMUL2 and HMIX
// (three multiplies). On the last request, tail bytes pass KMUL1 and KMUL2,
// a completed block also passes HMIX, then the final mix runs in FIN1 and FIN2.
// s_tready is low while the sequencer is busy.
// The result sits in an output register; new bytes keep being accepted while
// it waits, and the sequencer holds only when a second hash is ready before
// the first one is taken.
// Reset (aresetn low, synchronous) clears the seed to zero, drops any message
// in progress and empties the output register.
`default_nettype none

module murmur3_x86_32_hash_stream
    import mm3_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,    // seed_value
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] data_byte
    input  wire logic        s_tuser,     // [0] byte_present
    input  wire logic        s_tlast,     // last_item
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata      // [31:0] hash_value
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KMUL1,
        ST_KMUL2,
        ST_HMIX,
        ST_FIN1,
        ST_FIN2
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] seed_reg;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] work_reg, work_next;
    logic [23:0] part_reg, part_next;
    logic [1:0]  pos_reg, pos_next;
    logic [31:0] len_reg, len_next;
    logic        active_reg, active_next;
    logic        last_reg, last_next;
    logic        tail_reg, tail_next;
    logic [31:0] out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    logic        s_accept;
    logic        out_blocked;
    logic [31:0] mul_a, mul_b, prod;
    logic [31:0] acc_base, len_base;
    logic [23:0] part_base;
    logic [1:0]  pos_base;
    logic [31:0] fin_in;

    assign cfg_ready   = 1'b1;
    assign s_tready    = (state_reg == ST_IDLE);
    assign s_accept    = s_tvalid && s_tready;
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = out_reg;
    assign out_blocked = out_valid_reg && !m_tready;

    assign acc_base  = active_reg ? acc_reg  : seed_reg;
    assign len_base  = active_reg ? len_reg  : 32'd0;
    assign part_base = active_reg ? part_reg : 24'd0;
    assign pos_base  = active_reg ? pos_reg  : 2'd0;
    assign fin_in    = acc_reg ^ len_reg ^ (tail_reg ? work_reg : 32'd0);

    always_comb begin
        unique case (state_reg)
            ST_KMUL1: begin
                mul_a = work_reg;
                mul_b = MIX_C1;
            end
            ST_KMUL2: begin
                mul_a = work_reg;
                mul_b = MIX_C2;
            end
            ST_HMIX: begin
                mul_a = rotl13(acc_reg ^ work_reg);
                mul_b = MIX_M5;
            end
            ST_FIN1: begin
                mul_a = fin_in ^ {16'd0, fin_in[31:16]};
                mul_b = FIN_M1;
            end
            ST_FIN2: begin
                mul_a = work_reg ^ {13'd0, work_reg[31:13]};
                mul_b = FIN_M2;
            end
            default: begin
                mul_a = work_reg;
                mul_b = MIX_M5;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        work_next      = work_reg;
        part_next      = part_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        active_next    = active_reg;
        last_next      = last_reg;
        tail_next      = tail_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    acc_next    = acc_base;
                    len_next    = len_base;
                    part_next   = part_base;
                    pos_next    = pos_base;
                    active_next = !s_tlast;
                    last_next   = s_tlast;
                    tail_next   = 1'b0;
                    if (s_tuser) begin
                        len_next = len_base + 32'd1;
                        case (pos_base)
                            2'd0: part_next = {16'd0, s_tdata};
                            2'd1: part_next = {8'd0, s_tdata, part_base[7:0]};
                            2'd2: part_next = {s_tdata, part_base[15:0]};
                            default: part_next = 24'd0;
                        endcase
                        pos_next = pos_base + 2'd1;
                    end
                    if (s_tuser && pos_base == 2'd3) begin
                        work_next  = {s_tdata, part_base};
                        state_next = ST_KMUL1;
                    end else if (s_tlast) begin
                        if (pos_next != 2'd0) begin
                            work_next  = {8'd0, part_next};
                            tail_next  = 1'b1;
                            state_next = ST_KMUL1;
                        end else begin
                            state_next = ST_FIN1;
                        end
                    end
                end
            end
            ST_KMUL1: begin
                work_next  = rotl15(prod);
                state_next = ST_KMUL2;
            end
            ST_KMUL2: begin
                work_next  = prod;
                state_next = tail_reg ? ST_FIN1 : ST_HMIX;
            end
            ST_HMIX: begin
                acc_next   = prod + MIX_ADD;
                state_next = last_reg ? ST_FIN1 : ST_IDLE;
            end
            ST_FIN1: begin
                work_next  = prod;
                state_next = ST_FIN2;
            end
            ST_FIN2: begin
                if (!out_blocked) begin
                    out_next       = prod ^ {16'd0, prod[31:16]};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            seed_reg      <= 32'd0;
            active_reg    <= 1'b0;
            last_reg      <= 1'b0;
            tail_reg      <= 1'b0;
            pos_reg       <= 2'd0;
            part_reg      <= 24'd0;
            len_reg       <= 32'd0;
            acc_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_valid && cfg_ready) begin
                seed_reg <= cfg_data;
            end
            active_reg    <= active_next;
            last_reg      <= last_next;
            tail_reg      <= tail_next;
            pos_reg       <= pos_next;
            part_reg      <= part_next;
            len_reg       <= len_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        out_reg  <= out_next;
    end

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_no_tail_in_block_mix, aclk, aresetn,
        !(state_reg == ST_HMIX && tail_reg), "tail scramble routed into block mix")
    `ASSERT_CLKD(a_last_ends_message, aclk, aresetn,
        s_accept && s_tlast |=> !active_reg, "message still open after last request")
    `ASSERT_CLKD(a_full_block_mixes, aclk, aresetn,
        s_accept && s_tuser && pos_base == 2'd3 |=> state_reg == ST_KMUL1,
        "completed block not sent to mixer")
    `ASSERT_CLKD(a_fin_delivers, aclk, aresetn,
        state_reg == ST_FIN2 && !out_blocked |=> m_tvalid && state_reg == ST_IDLE,
        "finished hash not delivered")

endmodule

`default_nettype wire

### bench/murmur3_x86_32_hash_stream_tb.sv
`default_nettype none

module murmur3_x86_32_hash_stream_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] K_C1  = 32'hcc9e2d51;
    localparam logic [31:0] K_C2  = 32'h1b873593;
    localparam logic [31:0] K_ADD = 32'he6546b64;
    localparam logic [31:0] K_M5  = 32'd5;
    localparam logic [31:0] K_F1  = 32'h85ebca6b;
    localparam logic [31:0] K_F2  = 32'hc2b2ae35;

    localparam int unsigned CYCLE_LIMIT  = 250000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned TAIL_CYCLES  = 24;
    localparam int unsigned PHASES       = 6;
    localparam int unsigned PHASE_GOAL   = 222;
    localparam int unsigned OPEN_PHASE   = 2;
    localparam int unsigned HOLD_AFTER   = 600;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DIRECTED_N   = 20;

    typedef struct packed {
        logic [7:0]  data;
        logic        present;
        logic        last;
        logic        known;
        logic [31:0] hash;
    } request_row_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;

    logic        row_known = 1'b0;
    logic [31:0] row_hash  = '0;

    logic [31:0] seed_reg = '0;
    logic [31:0] acc      = '0;
    logic [23:0] partial  = '0;
    logic [1:0]  npos     = '0;
    logic [31:0] msg_len  = '0;
    logic        msg_open = 1'b0;

    logic [31:0] hash_expected [$];
    logic [31:0] want_hash;

    int unsigned err_count      = 0;
    int unsigned cycle_count    = 0;
    int unsigned requests_sent  = 0;
    int unsigned hashes_checked = 0;
    int unsigned seeds_written  = 0;
    int unsigned longest_msg    = 0;
    int unsigned tx_mode        = 1;
    int unsigned rx_mode        = 1;
    bit          hold_off       = 1'b0;

    request_row_t directed_rows [DIRECTED_N] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, 32'h0000_0000},
        '{8'h5a, 1'b0, 1'b0, 1'b0, 32'h0},
        '{8'ha5, 1'b0, 1'b1, 1'b1, 32'h0000_0000},
        '{8'hff, 1'b1, 1'b1, 1'b0, 32'h0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'hff, 1'b1, 1'b1, 1'b0, 32'h0},
        '{8'h80, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h01, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h7f, 1'b1, 1'b1, 1'b0, 32'h0},
        '{8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'hff, 1'b1, 1'b1, 1'b0, 32'h0},
        '{8'h21, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'hc3, 1'b0, 1'b0, 1'b0, 32'h0},
        '{8'h43, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h65, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h87, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h5a, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h3c, 1'b0, 1'b1, 1'b0, 32'h0}
    };

    murmur3_x86_32_hash_stream dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("murmur3_x86_32_hash_stream test failed");
            $finish;
        end
    end

    function automatic logic [31:0] rol(input logic [31:0] v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic logic [31:0] murmur_scramble(input logic [31:0] k);
        logic [31:0] r;
        r = k * K_C1;
        r = rol(r, 15);
        r = r * K_C2;
        return r;
    endfunction

    function automatic logic [31:0] murmur_fmix(input logic [31:0] h);
        logic [31:0] r;
        r = h ^ (h >> 16);
        r = r * K_F1;
        r = r ^ (r >> 13);
        r = r * K_F2;
        r = r ^ (r >> 16);
        return r;
    endfunction

    function automatic int unsigned draw_gap(input int unsigned mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 14);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %08h expected %08h (cycle %0d)",
                 what, got, want, cycle_count);
        err_count++;
    endtask

    task automatic absorb_request(input logic [7:0] b, input logic present, input logic last);
        logic [31:0] h;
        if (!msg_open) begin
            acc      = seed_reg;
            partial  = '0;
            npos     = '0;
            msg_len  = '0;
            msg_open = 1'b1;
        end
        if (present) begin
            msg_len = msg_len + 32'd1;
            if (npos == 2'd3) begin
                h       = acc ^ murmur_scramble({b, partial});
                acc     = rol(h, 13) * K_M5 + K_ADD;
                partial = '0;
                npos    = '0;
            end else begin
                partial[npos*8 +: 8] = b;
                npos = npos + 2'd1;
            end
        end
        if (last) begin
            h = acc;
            if (npos != 2'd0)
                h = h ^ murmur_scramble({8'h00, partial});
            h = h ^ msg_len;
            if (msg_len > longest_msg)
                longest_msg = msg_len;
            hash_expected.push_back(row_known ? row_hash : murmur_fmix(h));
            msg_open = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                seed_reg = cfg_data;
                seeds_written++;
            end
            if (s_tvalid && s_tready)
                absorb_request(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready) begin
                if (hash_expected.size() == 0) begin
                    report_mismatch("hash with none pending", m_tdata, 32'h0);
                end else begin
                    want_hash = hash_expected.pop_front();
                    if (m_tdata !== want_hash)
                        report_mismatch("hash_value", m_tdata, want_hash);
                    hashes_checked++;
                end
            end
        end
    end

    // hold off the result side for a long stretch while requests keep coming
    initial begin
        while (requests_sent < HOLD_AFTER)
            @(negedge aclk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        hold_off = 1'b0;
    end

    initial begin
        int unsigned gap;
        int unsigned taken;
        taken = 0;
        @(negedge aclk);
        while (!aresetn)
            @(negedge aclk);
        forever begin
            if (taken % 8 == 0)
                rx_mode = $urandom_range(0, 2);
            gap = draw_gap(rx_mode);
            if (gap != 0 || hold_off) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
                while (hold_off)
                    @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid)
                @(posedge aclk);
            @(negedge aclk);
            taken++;
        end
    end

    task automatic drive_request(input logic [7:0] b, input logic present, input logic last,
                                 input logic known, input logic [31:0] hash);
        int unsigned gap;
        gap = draw_gap(tx_mode);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= b;
        s_tuser   <= present;
        s_tlast   <= last;
        row_known <= known;
        row_hash  <= hash;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
        requests_sent++;
    endtask

    task automatic send_message(input int unsigned len, input bit close);
        bit tail_empty;
        tx_mode = $urandom_range(0, 2);
        tail_empty = (len == 0) || ($urandom_range(0, 4) == 0);
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
                drive_request(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 32'h0);
            drive_request(8'($urandom_range(0, 255)), 1'b1,
                          close && !tail_empty && (i == len - 1), 1'b0, 32'h0);
        end
        if (close && tail_empty)
            drive_request(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, 32'h0);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (hash_expected.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [31:0] seed_plan [PHASES];
        int unsigned goal;
        int unsigned pick;
        int unsigned len;
        seed_plan[0] = 32'hffff_ffff;
        seed_plan[1] = 32'h0000_0000;
        seed_plan[2] = 32'h0000_0001;
        seed_plan[3] = 32'h8000_0000;
        seed_plan[4] = $urandom;
        seed_plan[5] = $urandom;

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        tx_mode = 1;
        for (int unsigned i = 0; i < DIRECTED_N; i++)
            drive_request(directed_rows[i].data, directed_rows[i].present,
                          directed_rows[i].last, directed_rows[i].known,
                          directed_rows[i].hash);
        drain();

        for (int unsigned p = 0; p < PHASES; p++) begin
            write_seed(seed_plan[p]);
            goal = requests_sent + PHASE_GOAL;
            while (requests_sent < goal) begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    len = 0;
                else if (pick < 85)
                    len = $urandom_range(1, 12);
                else if (pick < 97)
                    len = $urandom_range(13, 40);
                else
                    len = $urandom_range(41, 100);
                send_message(len, 1'b1);
            end
            // leave a message open across the next seed write
            if (p == OPEN_PHASE)
                send_message($urandom_range(3, 9), 1'b0);
            drain();
        end

        while (hash_expected.size() != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (hash_expected.size() != 0)
            report_mismatch("hashes never delivered", 32'h0, hash_expected.size());

        $display("Covered %0d requests and %0d hashes under %0d seed settings,",
                 requests_sent, hashes_checked, seeds_written);
        $display("messages up to %0d bytes, with a long result-side hold-off.", longest_msg);
        if (err_count == 0)
            $display("murmur3_x86_32_hash_stream test passed");
        else
            $display("murmur3_x86_32_hash_stream test failed");
        $finish;
    end

endmodule

`default_nettype wire
